// File: rtl/pbmd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pbmd_pkg;

   localparam int unsigned MAX_WIDTH_DEF  = 4096;
   localparam int unsigned MAX_HEIGHT_DEF = 4096;
   localparam int unsigned QDEPTH         = 2;

   localparam logic [7:0] CHAR_P     = 8'h50;
   localparam logic [7:0] CHAR_FOUR  = 8'h34;
   localparam logic [7:0] CHAR_HASH  = 8'd35;
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;
   localparam logic [7:0] CHAR_TAB   = 8'd9;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_SPACE = 8'd32;

   typedef enum logic [1:0] {
      KIND_PIXEL  = 2'd0,
      KIND_HEADER = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_MAGIC  = 2'd0,
      ERR_WIDTH  = 2'd1,
      ERR_HEIGHT = 2'd2,
      ERR_SIZE   = 2'd3
   } err_type;

   typedef enum logic [1:0] {
      OP_PIXELS = 2'd0,
      OP_HEADER = 2'd1,
      OP_ERROR  = 2'd2
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
      err_type    err;
   } cmd_type;

   typedef struct packed {
      kind_type    kind;
      logic        black;
      logic [11:0] column;
      logic [11:0] line;
      logic [12:0] image_width;
      logic [12:0] image_height;
      err_type     error_code;
      logic        last_of_run;
      logic        end_of_image;
   } rsp_word_type;

   function automatic logic is_ws(input logic [7:0] c);
      return ((c >= CHAR_TAB) && (c <= CHAR_CR)) || (c == CHAR_SPACE);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

endpackage
`default_nettype wire

// File: rtl/pbmd_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface pbmd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] file_byte;

   modport source (output valid, output file_byte, input ready);
   modport sink (input valid, input file_byte, output ready);
endinterface
`default_nettype wire

// File: rtl/pbmd_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface pbmd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic        black;
   logic [11:0] column;
   logic [11:0] line;
   logic [12:0] image_width;
   logic [12:0] image_height;
   logic [1:0]  error_code;
   logic        last_of_run;
   logic        end_of_image;

   modport source (output valid, output kind, output black, output column, output line,
                   output image_width, output image_height, output error_code,
                   output last_of_run, output end_of_image, input ready);
   modport sink (input valid, input kind, input black, input column, input line,
                 input image_width, input image_height, input error_code,
                 input last_of_run, input end_of_image, output ready);
endinterface
`default_nettype wire

// File: rtl/pbmd_front.sv
`timescale 1ns / 1ps
`default_nettype none
module pbmd_front #(
   parameter int unsigned MAX_WIDTH  = pbmd_pkg::MAX_WIDTH_DEF,
   parameter int unsigned MAX_HEIGHT = pbmd_pkg::MAX_HEIGHT_DEF,
   localparam int unsigned WW = $clog2(MAX_WIDTH + 1),
   localparam int unsigned HW = $clog2(MAX_HEIGHT + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_file_byte,
   input  logic              q_full,
   output logic              q_push,
   output pbmd_pkg::cmd_type q_cmd,
   output logic [WW-1:0]     img_width,
   output logic [HW-1:0]     img_height
);
   import pbmd_pkg::*;

   typedef enum logic [3:0] {
      PH_P, PH_FOUR, PH_SKIP, PH_COMMENT, PH_WIDTH,
      PH_SEP, PH_HEIGHT, PH_BODY, PH_ERR
   } phase_type;

   phase_type      phase_ff, phase_in;
   logic [WW-1:0]  width_ff, width_in;
   logic [HW-1:0]  height_ff, height_in;
   err_type        err_ff, err_in;

   logic           accept;
   logic [3:0]     dval;
   logic [WW-1:0]  wbase;
   logic [HW-1:0]  hbase;
   logic [WW+3:0]  wsum;
   logic [HW+3:0]  hsum;
   logic           w_big;
   logic           h_big;

   assign req_ready  = !q_full;
   assign accept     = req_valid && req_ready;
   assign img_width  = width_ff;
   assign img_height = height_ff;

   // acc * 10 + digit, wide enough never to wrap
   assign dval  = 4'(req_file_byte - CHAR_ZERO);
   assign wbase = (phase_ff == PH_WIDTH) ? width_ff : '0;
   assign hbase = (phase_ff == PH_HEIGHT) ? height_ff : '0;
   assign wsum  = (WW+4)'({wbase, 3'b000}) + (WW+4)'({wbase, 1'b0}) + (WW+4)'(dval);
   assign hsum  = (HW+4)'({hbase, 3'b000}) + (HW+4)'({hbase, 1'b0}) + (HW+4)'(dval);
   assign w_big = wsum > (WW+4)'(MAX_WIDTH);
   assign h_big = hsum > (HW+4)'(MAX_HEIGHT);

   always_comb begin
      logic    fail_now;
      err_type fail_code;
      fail_now  = 1'b0;
      fail_code = ERR_MAGIC;
      phase_in  = phase_ff;
      width_in  = width_ff;
      height_in = height_ff;
      err_in    = err_ff;
      q_push    = 1'b0;
      q_cmd     = '{op: OP_PIXELS, data: req_file_byte, err: err_ff};
      if (accept) begin
         unique case (phase_ff)
            PH_P: begin
               if (req_file_byte != CHAR_P) begin
                  fail_now = 1'b1;
               end else begin
                  phase_in = PH_FOUR;
               end
            end
            PH_FOUR: begin
               if (req_file_byte != CHAR_FOUR) begin
                  fail_now = 1'b1;
               end else begin
                  phase_in = PH_SKIP;
               end
            end
            PH_SKIP, PH_WIDTH: begin
               if (is_ws(req_file_byte)) begin
                  if (phase_ff == PH_WIDTH) phase_in = PH_SEP;
               end else if (phase_ff == PH_SKIP && req_file_byte == CHAR_HASH) begin
                  phase_in = PH_COMMENT;
               end else if (!is_digit(req_file_byte)) begin
                  fail_now  = 1'b1;
                  fail_code = ERR_WIDTH;
               end else if (w_big) begin
                  fail_now  = 1'b1;
                  fail_code = ERR_SIZE;
               end else begin
                  width_in = WW'(wsum);
                  phase_in = PH_WIDTH;
               end
            end
            PH_COMMENT: begin
               if (req_file_byte == CHAR_LF) phase_in = PH_SKIP;
            end
            PH_SEP, PH_HEIGHT: begin
               if (is_ws(req_file_byte)) begin
                  if (phase_ff == PH_HEIGHT) begin
                     q_push   = 1'b1;
                     q_cmd.op = OP_HEADER;
                     phase_in = PH_BODY;
                  end
               end else if (!is_digit(req_file_byte)) begin
                  fail_now  = 1'b1;
                  fail_code = ERR_HEIGHT;
               end else if (h_big) begin
                  fail_now  = 1'b1;
                  fail_code = ERR_SIZE;
               end else begin
                  height_in = HW'(hsum);
                  phase_in  = PH_HEIGHT;
               end
            end
            PH_BODY: begin
               // back end drops bytes past the last row
               q_push = 1'b1;
            end
            PH_ERR: begin
               q_push   = 1'b1;
               q_cmd.op = OP_ERROR;
            end
            default: begin
               phase_in = PH_ERR;
            end
         endcase
         if (fail_now) begin
            phase_in  = PH_ERR;
            err_in    = fail_code;
            q_push    = 1'b1;
            q_cmd.op  = OP_ERROR;
            q_cmd.err = fail_code;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_P;
         width_ff  <= '0;
         height_ff <= '0;
         err_ff    <= ERR_MAGIC;
      end else begin
         phase_ff  <= phase_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         err_ff    <= err_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/pbmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module pbmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pbmd_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output pbmd_pkg::cmd_type head_cmd
);
   import pbmd_pkg::*;

   localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int unsigned CW = $clog2(QDEPTH + 1);

   cmd_type         entry_ff [QDEPTH];
   logic [PW-1:0]   wr_ptr_ff;
   logic [PW-1:0]   rd_ptr_ff;
   logic [CW-1:0]   count_ff;
   logic            do_push;
   logic            do_pop;

   assign full       = (count_ff == CW'(QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

// File: rtl/pbmd_back.sv
`timescale 1ns / 1ps
`default_nettype none
module pbmd_back #(
   parameter int unsigned MAX_WIDTH  = pbmd_pkg::MAX_WIDTH_DEF,
   parameter int unsigned MAX_HEIGHT = pbmd_pkg::MAX_HEIGHT_DEF,
   localparam int unsigned WW = $clog2(MAX_WIDTH + 1),
   localparam int unsigned HW = $clog2(MAX_HEIGHT + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  pbmd_pkg::cmd_type      head_cmd,
   output logic                   pop,
   input  logic [WW-1:0]          img_width,
   input  logic [HW-1:0]          img_height,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output pbmd_pkg::rsp_word_type rsp_word
);
   import pbmd_pkg::*;

   logic           valid_ff, valid_in;
   rsp_word_type   word_ff, word_in;
   logic [WW-1:0]  col_ff, col_in;
   logic [HW-1:0]  row_ff, row_in;
   logic [2:0]     bit_ff, bit_in;
   logic           done_ff, done_in;

   logic           out_free;
   logic           row_end;
   logic           img_end;
   logic           last_px;

   assign out_free  = !valid_ff || rsp_ready;
   assign row_end   = (WW'(col_ff + 1'b1) == img_width);
   assign img_end   = row_end && (HW'(row_ff + 1'b1) == img_height);
   assign last_px   = row_end || (bit_ff == 3'd7);
   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

   always_comb begin
      valid_in = out_free ? 1'b0 : valid_ff;
      word_in  = word_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      bit_in   = bit_ff;
      done_in  = done_ff;
      pop      = 1'b0;
      if (head_valid) begin
         unique case (head_cmd.op)
            OP_ERROR: begin
               if (out_free) begin
                  pop      = 1'b1;
                  valid_in = 1'b1;
                  word_in  = '0;
                  word_in.kind        = KIND_ERROR;
                  word_in.error_code  = head_cmd.err;
                  word_in.last_of_run = 1'b1;
               end
            end
            OP_HEADER: begin
               if (out_free) begin
                  pop      = 1'b1;
                  valid_in = 1'b1;
                  word_in  = '0;
                  word_in.kind         = KIND_HEADER;
                  word_in.image_width  = 13'(img_width);
                  word_in.image_height = 13'(img_height);
                  word_in.last_of_run  = 1'b1;
                  col_in  = '0;
                  row_in  = '0;
                  bit_in  = '0;
                  done_in = (img_width == '0) || (img_height == '0);
               end
            end
            OP_PIXELS: begin
               if (done_ff) begin
                  // drop trailing bytes
                  pop = 1'b1;
               end else if (out_free) begin
                  valid_in = 1'b1;
                  word_in  = '0;
                  word_in.kind         = KIND_PIXEL;
                  word_in.black        = head_cmd.data[3'd7 - bit_ff];
                  word_in.column       = 12'(col_ff);
                  word_in.line         = 12'(row_ff);
                  word_in.last_of_run  = last_px;
                  word_in.end_of_image = img_end;
                  pop    = last_px;
                  bit_in = last_px ? 3'd0 : bit_ff + 1'b1;
                  if (row_end) begin
                     col_in = '0;
                     row_in = HW'(row_ff + 1'b1);
                     if (img_end) done_in = 1'b1;
                  end else begin
                     col_in = WW'(col_ff + 1'b1);
                  end
               end
            end
            default: begin
               pop = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      col_ff  <= col_in;
      row_ff  <= row_in;
      if (reset) begin
         valid_ff <= 1'b0;
         bit_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         bit_ff   <= bit_in;
         done_ff  <= done_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/pbm_p4_stream_decoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  dir  payload                                   handshake
// req_ch   in   file_byte                                 valid/ready
// rsp_ch   out  kind, black, column, line, image_width,   valid/ready
//               image_height, error_code, last_of_run,
//               end_of_image
//
// Header and error bytes each yield one result word; a raster byte yields one
// word per pixel (up to eight), issued one at a time by the single pixel emitter in the
// back end. A two-entry command queue sits between the parser and the emitter.
// Reset is synchronous; no clearing pass. Either side may stall at any time;
// a held result does not block the parser until the queue is full.
module pbm_p4_stream_decoder_top #(
   parameter int unsigned MAX_WIDTH  = pbmd_pkg::MAX_WIDTH_DEF,
   parameter int unsigned MAX_HEIGHT = pbmd_pkg::MAX_HEIGHT_DEF
) (
   input logic         clock,
   input logic         reset,
   pbmd_req_if.sink    req_ch,
   pbmd_rsp_if.source  rsp_ch
);
   import pbmd_pkg::*;

   localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
   localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);

   logic          q_full;
   logic          q_push;
   cmd_type       q_cmd;
   logic          q_pop;
   logic          head_valid;
   cmd_type       head_cmd;
   logic [WW-1:0] img_width;
   logic [HW-1:0] img_height;
   logic          rsp_valid;
   rsp_word_type  rsp_word;

   pbmd_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_file_byte (req_ch.file_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_cmd         (q_cmd),
      .img_width     (img_width),
      .img_height    (img_height)
   );

   pbmd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   pbmd_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (q_pop),
      .img_width  (img_width),
      .img_height (img_height),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ch.ready),
      .rsp_word   (rsp_word)
   );

   assign rsp_ch.valid        = rsp_valid;
   assign rsp_ch.kind         = rsp_word.kind;
   assign rsp_ch.black        = rsp_word.black;
   assign rsp_ch.column       = rsp_word.column;
   assign rsp_ch.line         = rsp_word.line;
   assign rsp_ch.image_width  = rsp_word.image_width;
   assign rsp_ch.image_height = rsp_word.image_height;
   assign rsp_ch.error_code   = rsp_word.error_code;
   assign rsp_ch.last_of_run  = rsp_word.last_of_run;
   assign rsp_ch.end_of_image = rsp_word.end_of_image;

endmodule
`default_nettype wire

// File: verif/tb_pbm_p4_stream_decoder_top.sv
`timescale 1ns / 1ps
module tb_pbm_p4_stream_decoder_top;
   import pbmd_pkg::*;

   // image carried by the test file; the header rows below spell these digits out
   localparam int IMG_W          = 13;
   localparam int IMG_H          = 200;
   localparam int RASTER_BYTES   = IMG_H * ((IMG_W + 7) / 8);
   localparam int DIR_COUNT      = 25;
   localparam int DIR_RASTER     = 4;
   localparam int TRAIL_BYTES    = 20;
   localparam int HOLD_AT        = 405;
   localparam int HOLD_CYCLES    = 120;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef enum int {
      SCAN_P, SCAN_FOUR, SCAN_SKIP, SCAN_COMMENT, SCAN_WIDTH,
      SCAN_SEP, SCAN_HEIGHT, SCAN_RASTER, SCAN_DONE, SCAN_FAILED
   } scan_state_type;

   typedef struct {
      logic [7:0]   data;
      bit           typed;
      rsp_word_type word;
   } dir_row_type;

   typedef struct {
      bit           typed;
      rsp_word_type word;
   } offer_type;

   localparam rsp_word_type HEADER_WORD = '{kind: KIND_HEADER, black: 1'b0,
      column: 12'd0, line: 12'd0, image_width: 13'(IMG_W), image_height: 13'(IMG_H),
      error_code: ERR_MAGIC, last_of_run: 1'b1, end_of_image: 1'b0};

   logic clock = 1'b0;
   logic reset = 1'b1;

   pbmd_req_if req_bus ();
   pbmd_rsp_if rsp_bus ();

   pbm_p4_stream_decoder_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always #1 clock = ~clock;

   // decoder state mirrored by the predictor
   scan_state_type scan = SCAN_P;
   err_type        sticky_code = ERR_MAGIC;
   int             img_w = 0;
   int             img_h = 0;
   int             col_pos = 0;
   int             row_pos = 0;
   rsp_word_type   step_words [8];

   rsp_word_type due_words [$];
   offer_type    offered_bytes [$];
   int           error_count = 0;

   logic         req_take = 1'b0;
   logic         rsp_take = 1'b0;
   logic [7:0]   taken_byte = '0;
   rsp_word_type seen = '0;

   int gap_pct = 0;
   int stall_pct = 0;
   int holds_asked = 0;
   int holds_granted = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   dir_row_type dir_rows [DIR_COUNT] = '{
      '{CHAR_P, 1'b0, '0},
      '{CHAR_FOUR, 1'b0, '0},
      '{CHAR_SPACE, 1'b0, '0},
      '{CHAR_HASH, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{CHAR_HASH, 1'b0, '0},
      '{CHAR_CR, 1'b0, '0},
      '{CHAR_LF, 1'b0, '0},
      '{CHAR_CR, 1'b0, '0},
      '{CHAR_TAB, 1'b0, '0},
      '{CHAR_ZERO, 1'b0, '0},
      '{CHAR_ZERO + 8'd1, 1'b0, '0},
      '{CHAR_ZERO + 8'd3, 1'b0, '0},
      '{8'd12, 1'b0, '0},
      '{8'd11, 1'b0, '0},
      '{CHAR_ZERO, 1'b0, '0},
      '{CHAR_ZERO + 8'd2, 1'b0, '0},
      '{CHAR_ZERO, 1'b0, '0},
      '{CHAR_ZERO, 1'b0, '0},
      '{CHAR_LF, 1'b1, HEADER_WORD},
      '{8'hFF, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'hA5, 1'b0, '0},
      '{8'h5A, 1'b0, '0}
   };

   function automatic bit is_blank(input logic [7:0] c);
      return (c >= CHAR_TAB && c <= CHAR_CR) || c == CHAR_SPACE;
   endfunction

   function automatic bit is_numeral(input logic [7:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
   endfunction

   function automatic int fail_with(input err_type code);
      rsp_word_type w;
      w = '0;
      w.kind = KIND_ERROR;
      w.error_code = code;
      w.last_of_run = 1'b1;
      step_words[0] = w;
      sticky_code = code;
      scan = SCAN_FAILED;
      return 1;
   endfunction

   // advance the mirrored decoder by one file byte; fill step_words, return the count
   function automatic int decode_file_byte(input logic [7:0] c);
      int v;
      int left;
      int cnt;
      rsp_word_type w;
      v = int'(c) - int'(CHAR_ZERO);
      case (scan)
         SCAN_FAILED: return fail_with(sticky_code);
         SCAN_P: begin
            if (c != CHAR_P) return fail_with(ERR_MAGIC);
            scan = SCAN_FOUR;
         end
         SCAN_FOUR: begin
            if (c != CHAR_FOUR) return fail_with(ERR_MAGIC);
            scan = SCAN_SKIP;
         end
         SCAN_SKIP: begin
            if (is_blank(c)) return 0;
            if (c == CHAR_HASH) begin
               scan = SCAN_COMMENT;
               return 0;
            end
            if (!is_numeral(c)) return fail_with(ERR_WIDTH);
            if (v > int'(MAX_WIDTH_DEF)) return fail_with(ERR_SIZE);
            img_w = v;
            scan = SCAN_WIDTH;
         end
         SCAN_COMMENT: begin
            if (c == CHAR_LF) scan = SCAN_SKIP;
         end
         SCAN_WIDTH: begin
            if (is_blank(c)) begin
               scan = SCAN_SEP;
               return 0;
            end
            if (!is_numeral(c)) return fail_with(ERR_WIDTH);
            v = img_w * 10 + v;
            if (v > int'(MAX_WIDTH_DEF)) return fail_with(ERR_SIZE);
            img_w = v;
         end
         SCAN_SEP: begin
            if (is_blank(c)) return 0;
            if (!is_numeral(c)) return fail_with(ERR_HEIGHT);
            if (v > int'(MAX_HEIGHT_DEF)) return fail_with(ERR_SIZE);
            img_h = v;
            scan = SCAN_HEIGHT;
         end
         SCAN_HEIGHT: begin
            if (is_blank(c)) begin
               w = '0;
               w.kind = KIND_HEADER;
               w.image_width = 13'(img_w);
               w.image_height = 13'(img_h);
               w.last_of_run = 1'b1;
               step_words[0] = w;
               col_pos = 0;
               row_pos = 0;
               scan = (img_w == 0 || img_h == 0) ? SCAN_DONE : SCAN_RASTER;
               return 1;
            end
            if (!is_numeral(c)) return fail_with(ERR_HEIGHT);
            v = img_h * 10 + v;
            if (v > int'(MAX_HEIGHT_DEF)) return fail_with(ERR_SIZE);
            img_h = v;
         end
         SCAN_RASTER: begin
            left = img_w - col_pos;
            cnt = (left < 8) ? left : 8;
            for (int i = 0; i < cnt; i++) begin
               w = '0;
               w.kind = KIND_PIXEL;
               w.black = c[7 - i];
               w.column = 12'(col_pos);
               w.line = 12'(row_pos);
               w.last_of_run = (i + 1 == cnt);
               w.end_of_image = (i + 1 == cnt) && (col_pos + 1 == img_w) &&
                                (row_pos + 1 == img_h);
               step_words[i] = w;
               col_pos++;
            end
            // drop the row padding bits and move to the next row
            if (col_pos >= img_w) begin
               col_pos = 0;
               row_pos++;
               if (row_pos >= img_h) scan = SCAN_DONE;
            end
            return cnt;
         end
         default: ;
      endcase
      return 0;
   endfunction

   task automatic report_error(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) report_error($sformatf("%s: got %0d, want %0d", name, got, want));
   endtask

   // sample both channels away from the rising edge
   always @(negedge clock) begin
      req_take = req_bus.valid && req_bus.ready;
      rsp_take = rsp_bus.valid && rsp_bus.ready;
      taken_byte = req_bus.file_byte;
      seen = {rsp_bus.kind, rsp_bus.black, rsp_bus.column, rsp_bus.line,
              rsp_bus.image_width, rsp_bus.image_height, rsp_bus.error_code,
              rsp_bus.last_of_run, rsp_bus.end_of_image};
   end

   always @(posedge clock) begin : scoreboard
      int n;
      offer_type o;
      rsp_word_type want;
      if (!reset) begin
         if (req_take) begin
            if (offered_bytes.size() == 0) begin
               report_error("byte taken that was never offered");
            end else begin
               o = offered_bytes.pop_front();
               n = decode_file_byte(taken_byte);
               if (o.typed) due_words.push_back(o.word);
               else for (int i = 0; i < n; i++) due_words.push_back(step_words[i]);
            end
         end
         if (rsp_take) begin
            if (due_words.size() == 0) begin
               report_error("result word with nothing expected");
            end else begin
               want = due_words.pop_front();
               check_field("kind", seen.kind, want.kind);
               check_field("black", seen.black, want.black);
               check_field("column", seen.column, want.column);
               check_field("line", seen.line, want.line);
               check_field("image_width", seen.image_width, want.image_width);
               check_field("image_height", seen.image_height, want.image_height);
               check_field("error_code", seen.error_code, want.error_code);
               check_field("last_of_run", seen.last_of_run, want.last_of_run);
               check_field("end_of_image", seen.end_of_image, want.end_of_image);
            end
         end
      end
   end

   // result side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b1;
      end else if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_granted != holds_asked) begin
         holds_granted <= holds_granted + 1;
         hold_left <= HOLD_CYCLES - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || req_take || rsp_take) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input int idx, input logic [7:0] b, input bit typed,
                            input rsp_word_type word);
      offer_type o;
      // drain everything before the phases that start at items 120, 220 and 320
      if (idx == 120 || idx == 220 || idx == 320) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while (due_words.size() != 0 || offered_bytes.size() != 0);
      end
      if (idx == HOLD_AT) holds_asked++;
      if (idx < DIR_COUNT) begin
         gap_pct = 22;
         stall_pct <= 22;
      end else if (idx < 120) begin
         gap_pct = 0;
         stall_pct <= 0;
      end else if (idx < 220) begin
         gap_pct = 59;
         stall_pct <= 0;
      end else if (idx < 320) begin
         gap_pct = 0;
         stall_pct <= 59;
      end else if (idx < 400) begin
         gap_pct = 22;
         stall_pct <= 22;
      end else begin
         gap_pct = 0;
         stall_pct <= 0;
      end
      while ($urandom_range(99) < gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      o.typed = typed;
      o.word = word;
      offered_bytes.push_back(o);
      req_bus.valid <= 1'b1;
      req_bus.file_byte <= b;
      do @(posedge clock); while (!req_take);
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.file_byte = '0;
      rsp_bus.ready = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIR_COUNT; r++)
         send_item(r, dir_rows[r].data, dir_rows[r].typed, dir_rows[r].word);

      for (int k = 0; k < RASTER_BYTES - DIR_RASTER; k++)
         send_item(DIR_COUNT + k, 8'($urandom_range(255)), 1'b0, '0);

      // bytes past the last row must be swallowed
      for (int k = 0; k < TRAIL_BYTES; k++)
         send_item(DIR_COUNT + RASTER_BYTES - DIR_RASTER + k, 8'($urandom_range(255)),
                   1'b0, '0);

      req_bus.valid <= 1'b0;
      while (due_words.size() != 0 || offered_bytes.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: pbm_p4_stream_decoder_top.f
rtl/pbmd_pkg.sv
rtl/pbmd_req_if.sv
rtl/pbmd_rsp_if.sv
rtl/pbmd_front.sv
rtl/pbmd_fifo.sv
rtl/pbmd_back.sv
rtl/pbm_p4_stream_decoder_top.sv
verif/tb_pbm_p4_stream_decoder_top.sv
